// ===== design/lrdg_pkg.sv =====
package lrdg_pkg;

  localparam int FRAC_BITS  = 15;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 20;
  localparam int PHASE_W    = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int GAIN_SEL_W = 4;

  // unity in the phase accumulator, one bit wider for the carry out of the add
  localparam logic [PHASE_W:0] PHASE_ONE = (PHASE_W + 1)'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_RATE_EN    = 2'd1,
    REG_CHAN_MODE  = 2'd2,
    REG_GAIN_SEL   = 2'd3
  } cfg_reg_t;

  // channel modes; the unused code behaves as mono
  localparam logic [1:0] MODE_MONO    = 2'd0;
  localparam logic [1:0] MODE_STEREO  = 2'd1;
  localparam logic [1:0] MODE_DOWNMIX = 2'd2;

  typedef struct packed {
    logic [4:0] mul;
    logic [2:0] shr;
    logic       sat;
  } gain_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
  } lane_pair_t;

  typedef struct packed {
    lane_pair_t           left;
    lane_pair_t           right;
    logic [FRAC_BITS-1:0] frac;
    logic                 emit;
  } front_out_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // x*mul >> shr; boosting entries saturate
  function automatic gain_t gain_lookup(input logic [GAIN_SEL_W-1:0] sel);
    gain_t g;
    case (sel)
      4'd0:    g = '{mul: 5'd1,  shr: 3'd0, sat: 1'b0};
      4'd1:    g = '{mul: 5'd11, shr: 3'd4, sat: 1'b0};
      4'd2:    g = '{mul: 5'd1,  shr: 3'd1, sat: 1'b0};
      4'd3:    g = '{mul: 5'd11, shr: 3'd5, sat: 1'b0};
      4'd4:    g = '{mul: 5'd1,  shr: 3'd2, sat: 1'b0};
      4'd5:    g = '{mul: 5'd11, shr: 3'd6, sat: 1'b0};
      4'd6:    g = '{mul: 5'd1,  shr: 3'd3, sat: 1'b0};
      4'd7:    g = '{mul: 5'd11, shr: 3'd7, sat: 1'b0};
      4'd8:    g = '{mul: 5'd1,  shr: 3'd4, sat: 1'b0};
      4'd9:    g = '{mul: 5'd9,  shr: 3'd3, sat: 1'b1};
      4'd10:   g = '{mul: 5'd5,  shr: 3'd2, sat: 1'b1};
      4'd11:   g = '{mul: 5'd25, shr: 3'd4, sat: 1'b1};
      4'd12:   g = '{mul: 5'd2,  shr: 3'd0, sat: 1'b1};
      4'd13:   g = '{mul: 5'd20, shr: 3'd3, sat: 1'b1};
      4'd14:   g = '{mul: 5'd25, shr: 3'd3, sat: 1'b1};
      4'd15:   g = '{mul: 5'd4,  shr: 3'd0, sat: 1'b1};
      default: g = '{mul: 5'd1,  shr: 3'd0, sat: 1'b0};
    endcase
    return g;
  endfunction

endpackage

// ===== design/linear_resampler_downmix_gain.sv =====
// Pipeline: an accepted input transaction passes the interpolation multiply stage, the
//   gain multiply stage and the output register on its way to out_tvalid.
// Throughput: one frame per cycle unless out_tready stalls; frames that fall between
//   output points take a slot in the front end only and yield no output transaction.
// Reset (rst_n, synchronous, active low): registers back to their defaults, phase
//   and held sample cleared, pipeline emptied. No clearing pass.
module linear_resampler_downmix_gain (
  input  logic        clk,
  input  logic        rst_n,
  // input frames
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] left_sample, [31:16] right_sample
  // output frames
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] out_left, [31:16] out_right
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  lrdg_pkg::front_out_t fo;
  lrdg_pkg::cfg_wr_t    cfg;
  lrdg_pkg::gain_t      gain;
  logic [lrdg_pkg::GAIN_SEL_W-1:0] gain_sel;

  logic accept;
  // valid flags of the two lane stages and the output register
  logic v1_r, v2_r, vo_r;
  logic rdy_o, rdy2, ld2, ldo, ld1;
  logic signed [lrdg_pkg::SAMPLE_W-1:0] y_left, y_right;
  logic [31:0] out_data_r;

  // register port never stalls
  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // per-stage handshake: a stage takes new data when empty or draining
  assign rdy_o     = !vo_r || out_tready;
  assign ldo       = v2_r && rdy_o;
  assign rdy2      = !v2_r || rdy_o;
  assign ld2       = v1_r && rdy2;
  assign in_tready = !v1_r || rdy2;
  assign accept    = in_tvalid && in_tready;
  assign ld1       = accept && fo.emit;

  lrdg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .left_sample  (in_tdata[15:0]),
    .right_sample (in_tdata[31:16]),
    .cfg          (cfg),
    .fo           (fo),
    .gain_sel     (gain_sel)
  );

  assign gain = lrdg_pkg::gain_lookup(gain_sel);

  // left (or mono) lane
  lrdg_lane u_lane_left (
    .clk  (clk),
    .ld1  (ld1),
    .ld2  (ld2),
    .pair (fo.left),
    .frac (fo.frac),
    .gain (gain),
    .y    (y_left)
  );

  // right lane; fed zeros in the mono modes
  lrdg_lane u_lane_right (
    .clk  (clk),
    .ld1  (ld1),
    .ld2  (ld2),
    .pair (fo.right),
    .frac (fo.frac),
    .gain (gain),
    .y    (y_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= 1'b1;
      end else if (ld2) begin
        v1_r <= 1'b0;
      end
      if (ld2) begin
        v2_r <= 1'b1;
      end else if (ldo) begin
        v2_r <= 1'b0;
      end
      if (ldo) begin
        vo_r <= 1'b1;
      end else if (out_tready) begin
        vo_r <= 1'b0;
      end
    end
  end

  // merge: both lanes land in one output transaction
  always_ff @(posedge clk) begin
    if (ldo) begin
      out_data_r <= {y_right, y_left};
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = out_data_r;

  a_emit_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    ld1 |=> v1_r)
    else $error("emitting frame did not reach the first lane stage");

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy_o) |=> v2_r)
    else $error("second lane stage dropped a result under back-pressure");

  a_reset_empties: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_tvalid && !v1_r && !v2_r))
    else $error("pipeline not empty after reset");

endmodule

// ===== design/lrdg_front.sv =====
module lrdg_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic signed [lrdg_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [lrdg_pkg::SAMPLE_W-1:0] right_sample,
  input  lrdg_pkg::cfg_wr_t                    cfg,
  output lrdg_pkg::front_out_t                 fo,
  output logic [lrdg_pkg::GAIN_SEL_W-1:0]      gain_sel
);

  logic [lrdg_pkg::STEP_W-1:0]          phase_step_r;
  logic                                 rate_en_r;
  logic [1:0]                           mode_r;
  logic [lrdg_pkg::GAIN_SEL_W-1:0]      gain_sel_r;
  logic [lrdg_pkg::PHASE_W-1:0]         phase_r;
  logic [lrdg_pkg::PHASE_W-1:0]         phase_nxt;
  logic signed [lrdg_pkg::SAMPLE_W-1:0] prev_left_r;
  logic signed [lrdg_pkg::SAMPLE_W-1:0] prev_right_r;
  logic                                 have_prev_r;

  logic signed [lrdg_pkg::SAMPLE_W-1:0] l_eff;
  logic signed [lrdg_pkg::SAMPLE_W-1:0] r_eff;
  logic signed [lrdg_pkg::SAMPLE_W-1:0] downmix;
  logic                                 stereo;
  logic                                 below_one;
  logic [lrdg_pkg::PHASE_W:0]           p_sum;

  assign downmix   = (left_sample >>> 1) + (right_sample >>> 1);
  assign stereo    = (mode_r == lrdg_pkg::MODE_STEREO);
  assign l_eff     = (mode_r == lrdg_pkg::MODE_DOWNMIX) ? downmix : left_sample;
  assign r_eff     = stereo ? right_sample : '0;
  assign below_one = (phase_r[lrdg_pkg::PHASE_W-1:lrdg_pkg::FRAC_BITS] == '0);

  always_comb begin
    p_sum = {1'b0, phase_r};
    if (below_one) begin
      p_sum = p_sum + (lrdg_pkg::PHASE_W + 1)'(phase_step_r);
    end
    if (p_sum >= lrdg_pkg::PHASE_ONE) begin
      phase_nxt = lrdg_pkg::PHASE_W'(p_sum - lrdg_pkg::PHASE_ONE);
    end else begin
      phase_nxt = '0;
    end
  end

  // pass-through runs the interpolator at zero fraction with both taps equal
  always_comb begin
    if (!rate_en_r) begin
      fo.left.a  = l_eff;
      fo.left.b  = l_eff;
      fo.right.a = r_eff;
      fo.right.b = r_eff;
      fo.frac    = '0;
      fo.emit    = 1'b1;
    end else begin
      fo.left.a  = prev_left_r;
      fo.left.b  = l_eff;
      fo.right.a = stereo ? prev_right_r : '0;
      fo.right.b = r_eff;
      fo.frac    = phase_r[lrdg_pkg::FRAC_BITS-1:0];
      fo.emit    = have_prev_r && below_one;
    end
  end

  assign gain_sel = gain_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= lrdg_pkg::STEP_RESET;
      rate_en_r    <= 1'b0;
      mode_r       <= lrdg_pkg::MODE_MONO;
      gain_sel_r   <= '0;
      phase_r      <= '0;
      have_prev_r  <= 1'b0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
    end else if (cfg.we) begin
      case (cfg.index)
        lrdg_pkg::REG_PHASE_STEP: begin
          phase_step_r <= cfg.data[lrdg_pkg::STEP_W-1:0];
          phase_r      <= '0;
          have_prev_r  <= 1'b0;
        end
        lrdg_pkg::REG_RATE_EN: begin
          rate_en_r   <= cfg.data[0];
          phase_r     <= '0;
          have_prev_r <= 1'b0;
        end
        lrdg_pkg::REG_CHAN_MODE: begin
          mode_r      <= cfg.data[1:0];
          phase_r     <= '0;
          have_prev_r <= 1'b0;
        end
        lrdg_pkg::REG_GAIN_SEL: begin
          gain_sel_r <= cfg.data[lrdg_pkg::GAIN_SEL_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept && rate_en_r) begin
      if (have_prev_r) begin
        phase_r <= phase_nxt;
      end
      prev_left_r  <= l_eff;
      prev_right_r <= r_eff;
      have_prev_r  <= 1'b1;
    end
  end

endmodule

// ===== design/lrdg_lane.sv =====
module lrdg_lane (
  input  logic                                 clk,
  input  logic                                 ld1,
  input  logic                                 ld2,
  input  lrdg_pkg::lane_pair_t                 pair,
  input  logic [lrdg_pkg::FRAC_BITS-1:0]       frac,
  input  lrdg_pkg::gain_t                      gain,
  output logic signed [lrdg_pkg::SAMPLE_W-1:0] y
);

  localparam int DIFF_W = lrdg_pkg::SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + lrdg_pkg::FRAC_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int GPROD_W = lrdg_pkg::SAMPLE_W + 6;

  logic signed [lrdg_pkg::SAMPLE_W-1:0] a_r;
  logic signed [lrdg_pkg::SAMPLE_W-1:0] b_r;
  logic [lrdg_pkg::FRAC_BITS-1:0]       frac_r;
  logic signed [lrdg_pkg::SAMPLE_W-1:0] interp_r;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   base;
  logic signed [SUM_W-1:0]   sum;
  logic signed [GPROD_W-1:0] gprod;
  logic signed [GPROD_W-1:0] gshift;

  // a + (b - a) * frac, floor-shifted back to sample scale
  assign diff = DIFF_W'(b_r) - DIFF_W'(a_r);
  assign prod = PROD_W'(diff) * $signed({1'b0, frac_r});
  assign base = $signed({{(SUM_W - lrdg_pkg::SAMPLE_W - lrdg_pkg::FRAC_BITS){a_r[lrdg_pkg::SAMPLE_W-1]}},
                         a_r, {lrdg_pkg::FRAC_BITS{1'b0}}});
  assign sum  = base + SUM_W'(prod);

  assign gprod  = GPROD_W'(interp_r) * $signed({1'b0, gain.mul});
  assign gshift = gprod >>> gain.shr;

  always_comb begin
    if (gain.sat && (gshift > GPROD_W'(32767))) begin
      y = 16'sh7FFF;
    end else if (gain.sat && (gshift < -GPROD_W'(32768))) begin
      y = -16'sh8000;
    end else begin
      y = gshift[lrdg_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      a_r    <= pair.a;
      b_r    <= pair.b;
      frac_r <= frac;
    end
    if (ld2) begin
      interp_r <= sum[lrdg_pkg::FRAC_BITS+lrdg_pkg::SAMPLE_W-1:lrdg_pkg::FRAC_BITS];
    end
  end

endmodule
